### hdl/crwi_pkg.sv
// Shared constants and types for the cuckoo random-walk insert block.
`timescale 1ns / 1ps
package crwi_pkg;
    localparam int BUCKETS    = 1024;
    localparam int MAX_WALK   = 128;
    localparam int BKT_W      = 10;
    localparam int UNDO_W     = 7;
    localparam int KEY_W      = 64;
    localparam int META_W     = 45;  // valid, class, dir, four candidates
    localparam int UMETA_W    = 55;  // position and displaced meta
    localparam logic [31:0] PRNG_SEED = 32'd314159265;

    localparam logic [1:0] ST_PLACED = 2'd0;
    localparam logic [1:0] ST_FAILED = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;

    localparam logic [2:0] REG_ROLLBACK = 3'd0;
    localparam logic [2:0] REG_LIMIT    = 3'd1;
    localparam logic [2:0] REG_MASK0    = 3'd2;
    localparam logic [2:0] REG_MASK1    = 3'd3;
    localparam logic [2:0] REG_MASK2    = 3'd4;

    typedef struct packed {
        logic             valid;
        logic [1:0]       cls;
        logic [1:0]       dir;
        logic [3:0][9:0]  cand;
    } t_meta;

    function automatic logic [31:0] prng_step(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction
endpackage

### hdl/crwi_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module crwi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hdl/cuckoo_random_walk_insert.sv
// Top level of the cuckoo table with random-walk insert and rollback.
//
// Input channel: i_valid/o_stall with func, key, class, four candidate
// buckets and a slot index. Output channel: o_valid/i_stall with one result
// per input transaction (status, entry fields, steps used).
// Configuration is to be written over the APB-style port only while the
// block is idle; the block does not enforce this. One item is worked on at a
// time. Each walk step is a read and a write of one table slot through the
// memory port; a failed insert with rollback then adds an undo read and an
// undo write per step, newest step first.
// After reset the block runs a clearing pass over the 1024 valid bits of the
// table, one slot a cycle, and accepts no item until the pass is done.
// A finished result sits in the output register; a stalled receiver holds
// it, and the block takes no new item until the result is taken.
// The random generator is reset to its seed and is not rewound by rollback.
`timescale 1ns / 1ps
module cuckoo_random_walk_insert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [63:0] i_key,
    input  logic [1:0]  i_key_class,
    input  logic [9:0]  i_cand0,
    input  logic [9:0]  i_cand1,
    input  logic [9:0]  i_cand2,
    input  logic [9:0]  i_cand3,
    input  logic [9:0]  i_slot,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_entry_valid,
    output logic [63:0] o_entry_key,
    output logic [1:0]  o_entry_class,
    output logic [1:0]  o_entry_direction,
    output logic [7:0]  o_steps_used,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import crwi_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_STEP, S_CHECK, S_UNDO_RD, S_UNDO_WR, S_OUT
    } t_state;

    t_state r_state;

    logic       r_rollback;
    logic [7:0] r_limit;
    logic [1:0] r_mask0, r_mask1, r_mask2;
    logic [31:0] r_prng;

    // current walking entry
    logic [63:0] r_key;
    t_meta       r_cur;
    logic [9:0]  r_pos;
    logic [7:0]  r_steps, r_limit_eff, r_k;

    logic [1:0]  r_status;
    logic        r_evalid;
    logic [63:0] r_ekey;
    logic [1:0]  r_eclass, r_edir;
    logic [7:0]  r_esteps;
    logic        r_ovalid;

    logic [BKT_W:0] r_clr;

    // table memories
    logic             t_we;
    logic [9:0]       t_waddr, t_raddr;
    logic [63:0]      t_wkey, t_rkey;
    logic [META_W-1:0] t_wmeta, t_rmeta;
    logic             u_we;
    logic [UNDO_W-1:0] u_waddr, u_raddr;
    logic [63:0]      u_rkey;
    logic [UMETA_W-1:0] u_wmeta, u_rmeta;
    t_meta            old_meta, undo_meta;

    crwi_ram #(.WIDTH(KEY_W), .DEPTH(BUCKETS)) u_slot_keys (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wkey),
        .i_raddr(t_raddr), .o_rdata(t_rkey));
    crwi_ram #(.WIDTH(META_W), .DEPTH(BUCKETS)) u_slot_meta (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wmeta),
        .i_raddr(t_raddr), .o_rdata(t_rmeta));
    crwi_ram #(.WIDTH(KEY_W), .DEPTH(MAX_WALK)) u_undo_keys (
        .i_clk(i_clk), .i_we(u_we), .i_waddr(u_waddr), .i_wdata(t_rkey),
        .i_raddr(u_raddr), .o_rdata(u_rkey));
    crwi_ram #(.WIDTH(UMETA_W), .DEPTH(MAX_WALK)) u_undo_meta (
        .i_clk(i_clk), .i_we(u_we), .i_waddr(u_waddr), .i_wdata(u_wmeta),
        .i_raddr(u_raddr), .o_rdata(u_rmeta));

    assign old_meta  = t_meta'(t_rmeta);
    assign undo_meta = t_meta'(u_rmeta[META_W-1:0]);

    // direction selection for the next step
    logic [31:0] prng_nx;
    logic [1:0]  cmask, dir;
    assign prng_nx = prng_step(r_prng);
    always_comb begin
        unique case (r_cur.cls)
            2'd0:    cmask = r_mask0;
            2'd1:    cmask = r_mask1;
            default: cmask = r_mask2;
        endcase
    end
    assign dir = prng_nx[1:0] & cmask;

    t_meta step_meta;
    always_comb begin
        step_meta     = r_cur;
        step_meta.dir = dir;
    end

    always_comb begin
        t_we    = 1'b0;
        t_waddr = r_pos;
        t_wkey  = r_key;
        t_wmeta = META_W'(step_meta);
        t_raddr = r_pos;
        u_we    = 1'b0;
        u_waddr = r_steps[UNDO_W-1:0] - UNDO_W'(1);
        u_wmeta = {r_pos, t_rmeta};
        u_raddr = r_k[UNDO_W-1:0] - UNDO_W'(1);
        unique case (r_state)
            S_CLEAR: begin
                t_we    = 1'b1;
                t_waddr = r_clr[BKT_W-1:0];
                t_wmeta = '0;
            end
            S_IDLE: t_raddr = i_slot;
            S_STEP: begin
                t_we    = 1'b1;
                t_waddr = r_cur.cand[dir];
                t_raddr = r_cur.cand[dir];
            end
            S_CHECK: u_we = r_rollback && old_meta.valid;
            S_UNDO_WR: begin
                t_we    = 1'b1;
                t_waddr = u_rmeta[UMETA_W-1:META_W];
                t_wkey  = u_rkey;
                t_wmeta = META_W'(undo_meta);
            end
            default: ;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign pready  = 1'b1;

    always_comb begin
        unique case (paddr[4:2])
            REG_ROLLBACK: prdata = {31'd0, r_rollback};
            REG_LIMIT:    prdata = {24'd0, r_limit};
            REG_MASK0:    prdata = {30'd0, r_mask0};
            REG_MASK1:    prdata = {30'd0, r_mask1};
            REG_MASK2:    prdata = {30'd0, r_mask2};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_rollback <= 1'b0;
            r_limit    <= 8'd128;
            r_mask0    <= 2'd0;
            r_mask1    <= 2'd1;
            r_mask2    <= 2'd3;
            r_prng     <= PRNG_SEED;
            r_ovalid   <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr[4:2])
                    REG_ROLLBACK: r_rollback <= pwdata[0];
                    REG_LIMIT:    r_limit    <= pwdata[7:0];
                    REG_MASK0:    r_mask0    <= pwdata[1:0];
                    REG_MASK1:    r_mask1    <= pwdata[1:0];
                    REG_MASK2:    r_mask2    <= pwdata[1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (BKT_W+1)'(BUCKETS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_key         <= i_key;
                        r_cur.valid   <= 1'b1;
                        r_cur.cls     <= i_key_class;
                        r_cur.dir     <= 2'd0;
                        r_cur.cand    <= {i_cand3, i_cand2, i_cand1, i_cand0};
                        r_steps       <= '0;
                        r_limit_eff   <= (r_limit > 8'(MAX_WALK)) ? 8'(MAX_WALK) : r_limit;
                        r_state       <= i_func ? S_READ : S_STEP;
                        if (!i_func && r_limit == 8'd0) r_state <= S_CHECK;
                    end
                end
                S_READ: begin
                    r_status <= ST_READ;
                    r_evalid <= old_meta.valid;
                    r_ekey   <= old_meta.valid ? t_rkey : '0;
                    r_eclass <= old_meta.valid ? old_meta.cls : 2'd0;
                    r_edir   <= old_meta.valid ? old_meta.dir : 2'd0;
                    r_esteps <= '0;
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_STEP: begin
                    r_prng  <= prng_nx;
                    r_pos   <= r_cur.cand[dir];
                    r_steps <= r_steps + 8'd1;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    // Zero steps only happens for a zero walk limit.
                    if (r_steps != 8'd0 && !old_meta.valid) begin
                        r_status <= ST_PLACED;
                        r_evalid <= 1'b0;
                        r_ekey   <= '0;
                        r_eclass <= 2'd0;
                        r_edir   <= 2'd0;
                        r_esteps <= r_steps;
                        r_ovalid <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        if (r_steps != 8'd0) begin
                            r_key <= t_rkey;
                            r_cur <= old_meta;
                        end
                        if (r_steps != 8'd0 && r_steps < r_limit_eff) begin
                            r_state <= S_STEP;
                        end else begin
                            r_status <= ST_FAILED;
                            r_edir   <= 2'd0;
                            r_esteps <= r_steps;
                            r_k      <= r_steps;
                            if (r_rollback) begin
                                r_evalid <= 1'b0;
                                r_ekey   <= '0;
                                r_eclass <= 2'd0;
                                r_state  <= (r_steps == 8'd0) ? S_OUT : S_UNDO_RD;
                                r_ovalid <= (r_steps == 8'd0);
                            end else begin
                                r_evalid <= 1'b1;
                                r_ekey   <= (r_steps != 8'd0) ? t_rkey : r_key;
                                r_eclass <= (r_steps != 8'd0) ? old_meta.cls : r_cur.cls;
                                r_ovalid <= 1'b1;
                                r_state  <= S_OUT;
                            end
                        end
                    end
                end
                S_UNDO_RD: r_state <= S_UNDO_WR;
                S_UNDO_WR: begin
                    r_k <= r_k - 8'd1;
                    if (r_k == 8'd1) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_UNDO_RD;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid           = r_ovalid;
    assign o_status          = r_status;
    assign o_entry_valid     = r_evalid;
    assign o_entry_key       = r_ekey;
    assign o_entry_class     = r_eclass;
    assign o_entry_direction = r_edir;
    assign o_steps_used      = r_esteps;
endmodule
